@@ rtl/core/probe_health_window_tracker_defines.svh @@
// Assertion helpers shared by the RTL.
`ifndef PROBE_HEALTH_WINDOW_TRACKER_DEFINES_SVH
`define PROBE_HEALTH_WINDOW_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define PHWT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PHWT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/phwt_pkg.sv @@
`timescale 1ns / 1ps
package phwt_pkg;

   localparam int CFG_W       = 7;
   localparam int STATUS_W    = 10;
   localparam int TIME_W      = 24;
   localparam int RATE_W      = 3;
   localparam int FLAGS_W     = 7;
   localparam int COUNT_W     = 7;
   localparam int BITMAP_W    = 64;
   localparam int NUM_EVENTS  = 6;
   localparam int CHUNK_BITS  = 16;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 28;
   localparam int PROD_W      = TIME_W + RECIP_W;

   localparam logic [CFG_W-1:0]    DEF_WINDOW    = 7'd8;
   localparam logic [CFG_W-1:0]    DEF_THRESHOLD = 7'd3;
   localparam logic [CFG_W-1:0]    DEF_INITIAL   = 7'd2;
   localparam logic [STATUS_W-1:0] DEF_STATUS    = 10'd200;

   typedef struct packed {
      logic                operation;
      logic                connected_ipv4;
      logic                connected_ipv6;
      logic                send_ok;
      logic                send_error;
      logic                recv_ok;
      logic                recv_error;
      logic                status_valid;
      logic [STATUS_W-1:0] status_code;
      logic [TIME_W-1:0]   response_time;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  good_count;
      logic                healthy;
      logic [1:0]          transition;
      logic [TIME_W-1:0]   average_time;
      logic [BITMAP_W-1:0] happy_bits;
      logic [FLAGS_W-1:0]  newest_flags;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_WINDOW_SIZE,
      REG_GOOD_THRESHOLD,
      REG_INITIAL_GOOD,
      REG_EXPECTED_STATUS
   } csr_index_type;

   typedef enum logic [1:0] {
      TR_STILL_HEALTHY,
      TR_BACK_HEALTHY,
      TR_WENT_SICK,
      TR_STILL_SICK
   } transition_type;

   localparam logic OP_PROBE   = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // microprogram
   typedef logic [1:0] step_type;
   localparam step_type STEP_WAIT  = 2'd0;
   localparam step_type STEP_COUNT = 2'd1;
   localparam step_type STEP_EMIT  = 2'd2;

   typedef enum logic [1:0] {
      COND_JUMP,
      COND_WAIT_REQ,
      COND_LOOP,
      COND_HOLD_OUT
   } cond_type;

   typedef struct packed {
      cond_type cond;
      step_type target;
      logic     exec;
      logic     acc;
      logic     emit;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic last_chunk;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic take_req;
      logic exec;
      logic acc;
      logic emit;
   } ctrl_type;

   function automatic uword_type ucode(step_type step);
      uword_type w;
      w = '{cond: COND_JUMP, target: STEP_WAIT, exec: 1'b0, acc: 1'b0, emit: 1'b0};
      unique case (step)
         STEP_WAIT: begin
            w = '{cond: COND_WAIT_REQ, target: STEP_WAIT, exec: 1'b1, acc: 1'b0, emit: 1'b0};
         end
         STEP_COUNT: begin
            w = '{cond: COND_LOOP, target: STEP_COUNT, exec: 1'b0, acc: 1'b1, emit: 1'b0};
         end
         STEP_EMIT: begin
            w = '{cond: COND_HOLD_OUT, target: STEP_WAIT, exec: 1'b0, acc: 1'b0, emit: 1'b1};
         end
         default: begin
            w = '{cond: COND_JUMP, target: STEP_WAIT, exec: 1'b0, acc: 1'b0, emit: 1'b0};
         end
      endcase
      return w;
   endfunction

   // floor(2^27 / rate) + 1: exact floor quotient for 24-bit dividends
   function automatic logic [RECIP_W-1:0] recip(logic [RATE_W-1:0] rate);
      logic [RECIP_W-1:0] r;
      r = 28'd134217729;
      case (rate)
         3'd0:    r = 28'd134217729;
         3'd1:    r = 28'd134217729;
         3'd2:    r = 28'd67108865;
         3'd3:    r = 28'd44739243;
         3'd4:    r = 28'd33554433;
         3'd5:    r = 28'd26843546;
         3'd6:    r = 28'd22369622;
         3'd7:    r = 28'd19173962;
         default: r = 28'd134217729;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/phwt_seq.sv @@
`timescale 1ns / 1ps
module phwt_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  phwt_pkg::status_type  status,
   output phwt_pkg::ctrl_type    ctrl
);

   phwt_pkg::step_type  step_ff;
   phwt_pkg::step_type  step_in;
   phwt_pkg::uword_type word;
   logic                go;

   always_comb begin
      word    = phwt_pkg::ucode(step_ff);
      go      = 1'b0;
      step_in = step_ff;
      unique case (word.cond)
         phwt_pkg::COND_JUMP: begin
            go      = 1'b1;
            step_in = word.target;
         end
         phwt_pkg::COND_WAIT_REQ: begin
            if (status.req_valid) begin
               go      = 1'b1;
               step_in = step_ff + 2'd1;
            end
         end
         phwt_pkg::COND_LOOP: begin
            go      = 1'b1;
            step_in = status.last_chunk ? step_ff + 2'd1 : word.target;
         end
         phwt_pkg::COND_HOLD_OUT: begin
            if (!status.out_busy) begin
               go      = 1'b1;
               step_in = word.target;
            end
         end
      endcase
      ctrl.take_req = (word.cond == phwt_pkg::COND_WAIT_REQ);
      ctrl.exec     = word.exec & go;
      ctrl.acc      = word.acc & go;
      ctrl.emit     = word.emit & go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= phwt_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/core/probe_health_window_tracker.sv @@
// Channel  Dir  Beat                 Handshake
// req_     in   phwt_pkg::req_type   req_valid / req_stall
// rsp_     out  phwt_pkg::rsp_type   rsp_valid / rsp_stall
// csr_     in   csr_wdata (10 bits)  csr_we, csr_index
//
// The update lands at the accept edge, then the sequencer takes one step per 16-bit
// slice of the window popcount, then emits the result. The next beat is taken only
// in the wait step, so no new beat is accepted until the current item is emitted.
// rsp_stall holds the result register and keeps the sequencer in its emit step.
// Reset is synchronous, req_stall is high during it; happy history comes up as 3.
`timescale 1ns / 1ps
`include "probe_health_window_tracker_defines.svh"
module probe_health_window_tracker #(
   parameter int HISTORY_BITS = 64,
   parameter int MAX_RATE     = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  phwt_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output phwt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [phwt_pkg::STATUS_W-1:0]      csr_wdata
);

   localparam int NUM_CHUNKS = (HISTORY_BITS + phwt_pkg::CHUNK_BITS - 1) / phwt_pkg::CHUNK_BITS;
   localparam int PAD_BITS   = NUM_CHUNKS * phwt_pkg::CHUNK_BITS;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int IDX_W      = $clog2(PAD_BITS) + 1;
   localparam int RATE_RST   = (MAX_RATE < 4) ? MAX_RATE : 4;
   localparam logic [phwt_pkg::RATE_W-1:0] RATE_MAX   = phwt_pkg::RATE_W'(MAX_RATE);
   localparam logic [phwt_pkg::RATE_W-1:0] RATE_RESET = phwt_pkg::RATE_W'(RATE_RST);
   localparam logic [phwt_pkg::CFG_W-1:0]  HIST_LIM   = phwt_pkg::CFG_W'(HISTORY_BITS);
   localparam logic [HISTORY_BITS-1:0]     HIST_RESET = HISTORY_BITS'(3);
   localparam logic [CHUNK_W-1:0]          LAST_CHUNK = CHUNK_W'(NUM_CHUNKS - 1);

   // configuration
   logic [phwt_pkg::CFG_W-1:0]    window_ff, window_in;
   logic [phwt_pkg::CFG_W-1:0]    threshold_ff, threshold_in;
   logic [phwt_pkg::CFG_W-1:0]    initial_ff, initial_in;
   logic [phwt_pkg::STATUS_W-1:0] expected_ff, expected_in;

   // tracker state
   logic [HISTORY_BITS-1:0]          hist_ff, hist_in;
   logic [HISTORY_BITS-1:0]          ev_ff [phwt_pkg::NUM_EVENTS];
   logic [HISTORY_BITS-1:0]          ev_in [phwt_pkg::NUM_EVENTS];
   logic [phwt_pkg::RATE_W-1:0]      rate_ff, rate_in;
   logic [phwt_pkg::TIME_W-1:0]      avg_ff, avg_in;
   logic                             flag_ff, flag_in;

   // per-item working registers
   logic [phwt_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic                             neg_ff, neg_in;
   logic                             happy_ff, happy_in;
   logic                             still_ff, still_in;
   logic [phwt_pkg::FLAGS_W-1:0]     newest_ff, newest_in;
   logic [phwt_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [CHUNK_W-1:0]               chunk_ff, chunk_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   phwt_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   phwt_pkg::status_type             status;
   phwt_pkg::ctrl_type               ctrl;

   logic [phwt_pkg::CFG_W-1:0]       eff_window, eff_thr, ini;
   logic [phwt_pkg::STATUS_W-1:0]    eff_status;
   logic [HISTORY_BITS-1:0]          preload;
   logic [phwt_pkg::CFG_W:0]         ini_dbl;
   logic [phwt_pkg::RATE_W-1:0]      rate_restart, rate_inc;
   logic                             happy;
   logic [phwt_pkg::NUM_EVENTS-1:0]  ev_bits;
   logic [phwt_pkg::TIME_W:0]        diff, diff_neg;
   logic [phwt_pkg::TIME_W-1:0]      mag, quot, avg_next;
   logic [PAD_BITS-1:0]              padded;
   logic [phwt_pkg::CHUNK_BITS-1:0]  slice, live;
   logic [IDX_W-1:0]                 pos;
   logic [2:0]                       part [4];
   logic [4:0]                       pop;
   logic                             now, prev;
   logic [1:0]                       tr;

   phwt_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign status.req_valid  = req_valid;
   assign status.last_chunk = (chunk_ff == LAST_CHUNK);
   assign status.out_busy   = rsp_valid_ff & rsp_stall;

   assign req_stall = ~ctrl.take_req | reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // effective settings and per-item terms
   always_comb begin
      eff_window = (window_ff == '0) ? phwt_pkg::DEF_WINDOW : window_ff;
      if (eff_window > HIST_LIM) begin
         eff_window = HIST_LIM;
      end
      eff_thr    = (threshold_ff == '0) ? phwt_pkg::DEF_THRESHOLD : threshold_ff;
      eff_status = (expected_ff == '0) ? phwt_pkg::DEF_STATUS : expected_ff;
      ini        = (initial_ff > eff_thr) ? eff_thr : initial_ff;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         preload[i] = (phwt_pkg::CFG_W'(i) < ini);
      end
      ini_dbl      = {ini, 1'b0};
      rate_restart = (ini_dbl > (phwt_pkg::CFG_W + 1)'(MAX_RATE)) ? RATE_MAX
                                                                   : ini_dbl[phwt_pkg::RATE_W-1:0];
      rate_inc     = (rate_ff < RATE_MAX) ? rate_ff + 3'd1 : rate_ff;

      happy   = req_data.recv_ok & req_data.status_valid & (req_data.status_code == eff_status);
      ev_bits = {req_data.recv_ok, req_data.recv_error, req_data.send_ok,
                 req_data.send_error, req_data.connected_ipv6, req_data.connected_ipv4};

      diff     = {1'b0, req_data.response_time} - {1'b0, avg_ff};
      diff_neg = '0 - diff;
      mag      = diff[phwt_pkg::TIME_W] ? diff_neg[phwt_pkg::TIME_W-1:0]
                                        : diff[phwt_pkg::TIME_W-1:0];
      prod_in  = mag * phwt_pkg::recip(rate_inc);
   end

   // one 16-bit slice of the windowed popcount
   always_comb begin
      padded = PAD_BITS'(hist_ff);
      slice  = padded[chunk_ff * phwt_pkg::CHUNK_BITS +: phwt_pkg::CHUNK_BITS];
      pos    = '0;
      for (int j = 0; j < phwt_pkg::CHUNK_BITS; j++) begin
         pos     = IDX_W'(chunk_ff) * IDX_W'(phwt_pkg::CHUNK_BITS) + IDX_W'(j);
         live[j] = slice[j] & (8'(pos) < 8'(eff_window));
      end
      for (int g = 0; g < 4; g++) begin
         part[g] = '0;
         for (int b = 0; b < 4; b++) begin
            part[g] = part[g] + 3'(live[4 * g + b]);
         end
      end
      pop = 5'(part[0]) + 5'(part[1]) + 5'(part[2]) + 5'(part[3]);
   end

   // health and average at emit
   always_comb begin
      now      = (cnt_ff >= eff_thr);
      prev     = still_ff ? now : flag_ff;
      if (now) begin
         tr = prev ? phwt_pkg::TR_STILL_HEALTHY : phwt_pkg::TR_BACK_HEALTHY;
      end else begin
         tr = prev ? phwt_pkg::TR_WENT_SICK : phwt_pkg::TR_STILL_SICK;
      end
      quot     = prod_ff[phwt_pkg::RECIP_SHIFT +: phwt_pkg::TIME_W];
      avg_next = avg_ff;
      if (happy_ff) begin
         avg_next = neg_ff ? avg_ff - quot : avg_ff + quot;
      end
   end

   always_comb begin
      window_in    = window_ff;
      threshold_in = threshold_ff;
      initial_in   = initial_ff;
      expected_in  = expected_ff;
      hist_in      = hist_ff;
      ev_in        = ev_ff;
      rate_in      = rate_ff;
      avg_in       = avg_ff;
      flag_in      = flag_ff;
      neg_in       = neg_ff;
      happy_in     = happy_ff;
      still_in     = still_ff;
      newest_in    = newest_ff;
      cnt_in       = cnt_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            phwt_pkg::REG_WINDOW_SIZE:     window_in    = csr_wdata[phwt_pkg::CFG_W-1:0];
            phwt_pkg::REG_GOOD_THRESHOLD:  threshold_in = csr_wdata[phwt_pkg::CFG_W-1:0];
            phwt_pkg::REG_INITIAL_GOOD:    initial_in   = csr_wdata[phwt_pkg::CFG_W-1:0];
            phwt_pkg::REG_EXPECTED_STATUS: expected_in  = csr_wdata;
            default: ;
         endcase
      end

      if (ctrl.exec) begin
         cnt_in   = '0;
         chunk_in = '0;
         if (req_data.operation == phwt_pkg::OP_RESTART) begin
            hist_in = preload;
            for (int k = 0; k < phwt_pkg::NUM_EVENTS; k++) begin
               ev_in[k] = '0;
            end
            avg_in    = '0;
            rate_in   = rate_restart;
            happy_in  = 1'b0;
            neg_in    = 1'b0;
            still_in  = (ini != '0);
            newest_in = {(ini != '0), 6'b0};
         end else begin
            hist_in = {hist_ff[HISTORY_BITS-2:0], happy};
            for (int k = 0; k < phwt_pkg::NUM_EVENTS; k++) begin
               ev_in[k] = {ev_ff[k][HISTORY_BITS-2:0], ev_bits[k]};
            end
            if (happy) begin
               rate_in = rate_inc;
            end
            happy_in  = happy;
            neg_in    = diff[phwt_pkg::TIME_W];
            still_in  = 1'b0;
            newest_in = {happy, ev_bits};
         end
      end

      if (ctrl.acc) begin
         cnt_in   = cnt_ff + phwt_pkg::COUNT_W'(pop);
         chunk_in = chunk_ff + CHUNK_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         avg_in                   = avg_next;
         flag_in                  = now;
         rsp_valid_in             = 1'b1;
         rsp_data_in.good_count   = cnt_ff;
         rsp_data_in.healthy      = now;
         rsp_data_in.transition   = tr;
         rsp_data_in.average_time = avg_next;
         rsp_data_in.happy_bits   = phwt_pkg::BITMAP_W'(hist_ff);
         rsp_data_in.newest_flags = newest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= phwt_pkg::DEF_WINDOW;
         threshold_ff <= phwt_pkg::DEF_THRESHOLD;
         initial_ff   <= phwt_pkg::DEF_INITIAL;
         expected_ff  <= phwt_pkg::DEF_STATUS;
         hist_ff      <= HIST_RESET;
         for (int k = 0; k < phwt_pkg::NUM_EVENTS; k++) begin
            ev_ff[k] <= '0;
         end
         rate_ff      <= RATE_RESET;
         avg_ff       <= '0;
         flag_ff      <= 1'b0;
         happy_ff     <= 1'b0;
         still_ff     <= 1'b0;
         cnt_ff       <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
         initial_ff   <= initial_in;
         expected_ff  <= expected_in;
         hist_ff      <= hist_in;
         ev_ff        <= ev_in;
         rate_ff      <= rate_in;
         avg_ff       <= avg_in;
         flag_ff      <= flag_in;
         happy_ff     <= happy_in;
         still_ff     <= still_in;
         cnt_ff       <= cnt_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         prod_ff <= prod_in;
      end
      neg_ff      <= neg_in;
      newest_ff   <= newest_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PHWT_ASSERT_NEXT(a_one_beat_per_item, clock, reset, req_valid && !req_stall, req_stall, "sequencer took a second beat before finishing the item")
   `PHWT_ASSERT_SAME(a_count_in_range, clock, reset, rsp_valid, rsp_data.good_count <= phwt_pkg::COUNT_W'(HISTORY_BITS), "good count exceeds history depth")
   `PHWT_ASSERT_SAME(a_flag_matches_transition, clock, reset, rsp_valid, rsp_data.healthy == ((rsp_data.transition == phwt_pkg::TR_STILL_HEALTHY) || (rsp_data.transition == phwt_pkg::TR_BACK_HEALTHY)), "healthy flag disagrees with transition kind")

endmodule

@@ sim/probe_health_window_tracker_test.sv @@
`timescale 1ns / 1ps
module probe_health_window_tracker_test;
   import phwt_pkg::*;

   // flag bits in req_type field order
   localparam logic [6:0] F_V4   = 7'b1000000;
   localparam logic [6:0] F_V6   = 7'b0100000;
   localparam logic [6:0] F_SOK  = 7'b0010000;
   localparam logic [6:0] F_SERR = 7'b0001000;
   localparam logic [6:0] F_ROK  = 7'b0000100;
   localparam logic [6:0] F_RERR = 7'b0000010;
   localparam logic [6:0] F_SV   = 7'b0000001;
   localparam int PHASES     = 12;
   localparam int PHASE_BEATS = 100;

   typedef struct {
      bit          cfg;
      logic [9:0]  w;
      logic [9:0]  t;
      logic [9:0]  i;
      logic [9:0]  s;
      req_type     beat;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   // tracker model state
   logic [6:0]  win_reg;
   logic [6:0]  thr_reg;
   logic [6:0]  ini_reg;
   logic [9:0]  status_reg;
   logic [63:0] happy_hist;
   logic [2:0]  model_rate;
   logic [23:0] avg_time;
   logic        healthy_now;

   rsp_type      health_q[$];
   rsp_type      head;
   plan_row_type plan[$];
   int          fail_count = 0;
   int          results_checked = 0;
   int          probes_sent = 0;
   int          restarts_sent = 0;
   int          settings_used = 0;
   int          flips_seen = 0;
   int          send_odds = 0;
   int          stall_odds = 0;
   int          stall_left = 0;

   always #1 clock = ~clock;

   probe_health_window_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic rsp_type track_probe(input req_type b);
      logic [6:0]  win;
      logic [6:0]  thr;
      logic [6:0]  ini;
      logic [9:0]  want_code;
      logic [63:0] span;
      logic        happy;
      logic        prev;
      longint      diff;
      rsp_type     r;
      win = (win_reg == 0) ? DEF_WINDOW : win_reg;
      if (win > 64) win = 7'd64;
      thr = (thr_reg == 0) ? DEF_THRESHOLD : thr_reg;
      span = (win == 64) ? {64{1'b1}} : (64'd1 << win) - 64'd1;
      r = '0;
      if (b.operation == OP_RESTART) begin
         ini = (ini_reg > thr) ? thr : ini_reg;
         happy_hist = (ini >= 64) ? {64{1'b1}} : (64'd1 << ini) - 64'd1;
         avg_time = '0;
         model_rate = (ini >= 2) ? 3'd4 : 3'(2 * ini);
         prev = (ini != 0) ? ($countones(happy_hist & span) >= thr) : healthy_now;
         r.newest_flags = (ini != 0) ? 7'h40 : 7'h00;
      end else begin
         want_code = (status_reg == 0) ? DEF_STATUS : status_reg;
         happy = b.recv_ok && b.status_valid && (b.status_code == want_code);
         r.newest_flags = {happy, b.recv_ok, b.recv_error, b.send_ok, b.send_error,
                           b.connected_ipv6, b.connected_ipv4};
         happy_hist = {happy_hist[62:0], happy};
         if (happy) begin
            if (model_rate < 4) model_rate++;
            diff = longint'(b.response_time) - longint'(avg_time);
            avg_time = 24'(longint'(avg_time) + diff / longint'(model_rate));
         end
         prev = healthy_now;
      end
      r.good_count = 7'($countones(happy_hist & span));
      healthy_now = (r.good_count >= thr);
      r.healthy = healthy_now;
      if (healthy_now) begin
         r.transition = prev ? TR_STILL_HEALTHY : TR_BACK_HEALTHY;
      end else begin
         r.transition = prev ? TR_WENT_SICK : TR_STILL_SICK;
      end
      r.average_time = avg_time;
      r.happy_bits = happy_hist;
      return r;
   endfunction

   function automatic req_type mk(input logic op, input logic [6:0] fl,
                                  input logic [9:0] code, input logic [23:0] t);
      return req_type'({op, fl, code, t});
   endfunction

   function automatic void add_beat(input req_type b);
      plan.push_back('{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, b, 1'b0, rsp_type'('0)});
   endfunction

   function automatic void add_typed(input req_type b, input rsp_type w);
      plan.push_back('{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, b, 1'b1, w});
   endfunction

   function automatic void add_cfg(input logic [9:0] w, input logic [9:0] t,
                                   input logic [9:0] i, input logic [9:0] s);
      plan.push_back('{1'b1, w, t, i, s, req_type'('0), 1'b0, rsp_type'('0)});
   endfunction

   function automatic req_type next_beat();
      req_type b;
      int      roll;
      roll = $urandom_range(0, 99);
      b = '0;
      b.operation = (roll < 3) ? OP_RESTART : OP_PROBE;
      {b.connected_ipv4, b.connected_ipv6, b.send_ok, b.send_error, b.recv_ok,
       b.recv_error, b.status_valid} = 7'($urandom);
      b.status_code = 10'($urandom);
      b.response_time = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 5000));
      if (roll >= 3 && roll < 80) begin
         b.recv_ok = 1'b1;
         b.status_valid = 1'b1;
         b.status_code = (status_reg == 0) ? DEF_STATUS : status_reg;
         if (roll >= 70) b.status_code = b.status_code ^ 10'd1;
      end
      return b;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic push_beat(input req_type b, input bit typed, input rsp_type want);
      int      gap;
      rsp_type guess;
      gap = 0;
      if (send_odds != 0 && $urandom_range(1, send_odds) == 1) gap = $urandom_range(1, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = track_probe(b);
      health_q.push_back(typed ? want : guess);
      if (b.operation == OP_RESTART) restarts_sent++;
      else probes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (health_q.size() != 0) @(negedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [9:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_WINDOW_SIZE:    win_reg = v[6:0];
         REG_GOOD_THRESHOLD: thr_reg = v[6:0];
         REG_INITIAL_GOOD:   ini_reg = v[6:0];
         default:            status_reg = v;
      endcase
      @(negedge clock);
   endtask

   task automatic write_regs(input logic [9:0] w, input logic [9:0] t,
                             input logic [9:0] i, input logic [9:0] s);
      put_reg(REG_WINDOW_SIZE, w);
      put_reg(REG_GOOD_THRESHOLD, t);
      put_reg(REG_INITIAL_GOOD, i);
      put_reg(REG_EXPECTED_STATUS, s);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(1, 15);
      end
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (health_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            head = health_q.pop_front();
            results_checked++;
            if (head.transition == TR_BACK_HEALTHY || head.transition == TR_WENT_SICK) begin
               flips_seen++;
            end
            if (rsp_data.good_count !== head.good_count)
               report_mismatch($sformatf("good_count %0d, want %0d",
                                         rsp_data.good_count, head.good_count));
            if (rsp_data.healthy !== head.healthy)
               report_mismatch($sformatf("healthy %0b, want %0b",
                                         rsp_data.healthy, head.healthy));
            if (rsp_data.transition !== head.transition)
               report_mismatch($sformatf("transition %0d, want %0d",
                                         rsp_data.transition, head.transition));
            if (rsp_data.average_time !== head.average_time)
               report_mismatch($sformatf("average_time %0d, want %0d",
                                         rsp_data.average_time, head.average_time));
            if (rsp_data.happy_bits !== head.happy_bits)
               report_mismatch($sformatf("happy_bits %h, want %h",
                                         rsp_data.happy_bits, head.happy_bits));
            if (rsp_data.newest_flags !== head.newest_flags)
               report_mismatch($sformatf("newest_flags %h, want %h",
                                         rsp_data.newest_flags, head.newest_flags));
         end
      end
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int         w;
      int         t;
      int         i;
      int         ew;
      logic [9:0] s;
      win_reg = DEF_WINDOW;
      thr_reg = DEF_THRESHOLD;
      ini_reg = DEF_INITIAL;
      status_reg = DEF_STATUS;
      happy_hist = 64'd3;
      model_rate = 3'd4;
      avg_time = '0;
      healthy_now = 1'b0;

      add_typed(mk(OP_PROBE, 7'd0, 10'd0, 24'd0),
                '{7'd2, 1'b0, TR_STILL_SICK, 24'd0, 64'h6, 7'h00});
      add_typed(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd400),
                '{7'd3, 1'b1, TR_BACK_HEALTHY, 24'd100, 64'hD, 7'h69});
      add_typed(mk(OP_PROBE, 7'h7F, 10'd200, 24'hFFFFFF),
                '{7'd4, 1'b1, TR_STILL_HEALTHY, 24'd4194378, 64'h1B, 7'h7F});
      add_beat(mk(OP_PROBE, F_V6 | F_SOK | F_ROK, 10'd200, 24'd50));
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd999, 24'd60));
      add_beat(mk(OP_PROBE, F_V4 | F_SERR | F_RERR | F_SV, 10'd200, 24'd70));
      add_typed(mk(OP_RESTART, 7'h7F, 10'd200, 24'd5),
                '{7'd2, 1'b0, TR_STILL_SICK, 24'd0, 64'h3, 7'h40});
      add_beat(mk(OP_PROBE, F_V6 | F_SOK | F_ROK | F_SV, 10'd200, 24'd1000));
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd0));
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd1));
      add_cfg(10'd0, 10'd0, 10'd0, 10'd0);
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd5000));
      add_beat(mk(OP_RESTART, 7'd0, 10'd0, 24'd0));
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd77));
      add_beat(mk(OP_PROBE, F_V6 | F_SOK | F_ROK | F_SV, 10'd200, 24'd10));
      add_cfg(10'd64, 10'd64, 10'd64, 10'd999);
      add_typed(mk(OP_RESTART, 7'd0, 10'd0, 24'd0),
                '{7'd64, 1'b1, TR_STILL_HEALTHY, 24'd0, {64{1'b1}}, 7'h40});
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd998, 24'd9));
      add_beat(mk(OP_PROBE, F_V6 | F_SOK | F_ROK | F_SV, 10'd999, 24'hFFFFFF));
      add_cfg(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
      add_typed(mk(OP_RESTART, 7'd0, 10'd0, 24'd0),
                '{7'd64, 1'b0, TR_STILL_SICK, 24'd0, {64{1'b1}}, 7'h40});
      add_beat(mk(OP_PROBE, F_V4 | F_ROK | F_SV, 10'h3FF, 24'd123));
      add_cfg(10'd1, 10'd1, 10'd1, 10'd200);
      add_typed(mk(OP_RESTART, 7'd0, 10'd0, 24'd0),
                '{7'd1, 1'b1, TR_STILL_HEALTHY, 24'd0, 64'h1, 7'h40});
      add_beat(mk(OP_PROBE, 7'd0, 10'd0, 24'd0));
      add_beat(mk(OP_PROBE, F_V4 | F_SOK | F_ROK | F_SV, 10'd200, 24'd300));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_odds = 4;
      stall_odds = 4;

      foreach (plan[k]) begin
         if (plan[k].cfg) begin
            wait_drained();
            write_regs(plan[k].w, plan[k].t, plan[k].i, plan[k].s);
         end else begin
            push_beat(plan[k].beat, plan[k].typed, plan[k].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case ($urandom_range(0, 7))
            0:       w = 0;
            1:       w = $urandom_range(65, 127);
            2:       w = 64;
            default: w = $urandom_range(1, 16);
         endcase
         ew = (w == 0) ? 8 : ((w > 64) ? 64 : w);
         case ($urandom_range(0, 7))
            0:       t = 0;
            1:       t = $urandom_range(ew + 1, 127);
            default: t = $urandom_range(1, ew);
         endcase
         case ($urandom_range(0, 5))
            0:       i = 0;
            1:       i = $urandom_range(0, 127);
            default: i = $urandom_range(0, (t == 0) ? 3 : t);
         endcase
         case ($urandom_range(0, 5))
            0:       s = 10'd0;
            1:       s = 10'($urandom);
            default: s = 10'($urandom_range(200, 204));
         endcase
         write_regs({3'($urandom), 7'(w)}, {3'($urandom), 7'(t)},
                    {3'($urandom), 7'(i)}, s);
         if (ph == PHASES - 1) begin
            send_odds = 0;
            stall_odds = 0;
         end else begin
            send_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            push_beat(next_beat(), 1'b0, rsp_type'('0));
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      $display("covered %0d probe beats and %0d restarts across %0d register settings",
               probes_sent, restarts_sent, settings_used);
      $display("%0d result beats checked, %0d health flips, %0d mismatches",
               results_checked, flips_seen, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
